[hdl/bresenham_line_rasterizer_assert.svh]
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define BLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/blr_pkg.sv]
// ----------------------------------------------------------------------------
// blr_pkg
// shared types and constants of the line rasterizer
// ----------------------------------------------------------------------------
package blr_pkg;

	localparam int HALF_RANGE = 32;
	localparam int MAX_PIXELS = 2 * HALF_RANGE;
	localparam int CNT_W      = $clog2(MAX_PIXELS);
	localparam int COORD_W    = 6;
	localparam int COLOR_W    = 24;
	localparam int D_W        = COORD_W + 3;
	localparam int IN_W       = 48;
	localparam int OUT_W      = 40;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} blr_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} blr_cmd_t;

	typedef struct packed {
		logic last;
	} blr_stat_t;

endpackage

[hdl/blr_ctrl.sv]
// ----------------------------------------------------------------------------
// blr_ctrl
// controller: takes a line request, then walks its pixels out
// ----------------------------------------------------------------------------
module blr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  blr_pkg::blr_stat_t stat,
	output blr_pkg::blr_cmd_t  cmd
);
	import blr_pkg::*;

	blr_state_t state_q;
	blr_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.last) begin
						state_nxt = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/blr_dp.sv]
// ----------------------------------------------------------------------------
// blr_dp
// datapath: octant setup, decision term and pixel stepping
// ----------------------------------------------------------------------------
module blr_dp (
	input  logic                                 clk,
	input  logic signed [blr_pkg::COORD_W-1:0]   start_x,
	input  logic signed [blr_pkg::COORD_W-1:0]   start_y,
	input  logic signed [blr_pkg::COORD_W-1:0]   end_x,
	input  logic signed [blr_pkg::COORD_W-1:0]   end_y,
	input  logic        [blr_pkg::COLOR_W-1:0]   line_color,
	input  blr_pkg::blr_cmd_t                    cmd,
	output blr_pkg::blr_stat_t                   stat,
	output logic signed [blr_pkg::COORD_W-1:0]   pixel_x,
	output logic signed [blr_pkg::COORD_W-1:0]   pixel_y,
	output logic        [blr_pkg::COLOR_W-1:0]   pixel_color
);
	import blr_pkg::*;

	logic signed [COORD_W:0]   dx;
	logic signed [COORD_W:0]   dy;
	logic        [COORD_W:0]   ax_w;
	logic        [COORD_W:0]   ay_w;
	logic        [COORD_W-1:0] ax;
	logic        [COORD_W-1:0] ay;
	logic                      swap;
	logic        [COORD_W-1:0] major;
	logic        [COORD_W-1:0] minor;
	logic signed [D_W-1:0]     minor2;
	logic signed [D_W-1:0]     major1;
	logic signed [D_W-1:0]     major2;

	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic        [COLOR_W-1:0] color_q;
	logic        [COORD_W-1:0] rem_q;
	logic        [CNT_W-1:0]   cnt_q;
	logic signed [D_W-1:0]     d_q;
	logic signed [D_W-1:0]     diag_q;
	logic signed [D_W-1:0]     axial_q;
	logic                      swap_q;
	logic                      negx_q;
	logic                      negy_q;

	logic                      diag_step;
	logic                      x_move;
	logic                      y_move;
	logic        [COORD_W-1:0] x_inc;
	logic        [COORD_W-1:0] y_inc;

	// octant setup
	assign dx     = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
	assign dy     = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
	assign ax_w   = dx[COORD_W] ? -dx : dx;
	assign ay_w   = dy[COORD_W] ? -dy : dy;
	assign ax     = ax_w[COORD_W-1:0];
	assign ay     = ay_w[COORD_W-1:0];
	assign swap   = ax < ay;
	assign major  = swap ? ay : ax;
	assign minor  = swap ? ax : ay;
	assign minor2 = {2'b00, minor, 1'b0};
	assign major1 = {3'b000, major};
	assign major2 = {2'b00, major, 1'b0};

	// stepping
	assign diag_step = ~d_q[D_W-1];
	assign x_move    = !swap_q || diag_step;
	assign y_move    = swap_q || diag_step;
	assign x_inc     = negx_q ? {COORD_W{1'b1}} : COORD_W'(1);
	assign y_inc     = negy_q ? {COORD_W{1'b1}} : COORD_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= start_x;
			y_q     <= start_y;
			color_q <= line_color;
			rem_q   <= major;
			cnt_q   <= '0;
			d_q     <= minor2 - major1;
			diag_q  <= minor2 - major2;
			axial_q <= minor2;
			swap_q  <= swap;
			negx_q  <= dx[COORD_W];
			negy_q  <= dy[COORD_W];
		end else if (cmd.step) begin
			if (x_move) begin
				x_q <= x_q + $signed(x_inc);
			end
			if (y_move) begin
				y_q <= y_q + $signed(y_inc);
			end
			d_q   <= d_q + (diag_step ? diag_q : axial_q);
			rem_q <= rem_q - COORD_W'(1);
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign stat.last   = (rem_q == '0) || (cnt_q == CNT_W'(MAX_PIXELS - 1));
	assign pixel_x     = x_q;
	assign pixel_y     = y_q;
	assign pixel_color = color_q;

endmodule

[hdl/bresenham_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// integer line rasterizer, one line request in, one pixel request per step out
// ----------------------------------------------------------------------------
// input channel s_*: one line request (start, end, color) per handshake
// output channel m_*: one pixel per handshake, m_tlast marks the final pixel
// a line gives 1 + max(|dx|, |dy|) pixels, capped at 2 * HALF_RANGE
// the first pixel is valid in the cycle after the line is taken
// then one pixel per cycle while m_tready is high; the single stepping
// datapath advances by one pixel on each accepted output handshake
// a line holds the input channel from its request until its final pixel is taken
// s_tready is high only while no line is in progress
// a stalled receiver holds the current pixel in the output register
// reset (arst_n low) drops any line in progress and returns to idle
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// start_x, start_y, end_x, end_y, line_color
	input  logic [blr_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// pixel_x, pixel_y, pixel_color, zero pad
	output logic [blr_pkg::OUT_W-1:0]  m_tdata,
	output logic                       m_tlast
);
	import blr_pkg::*;

	blr_cmd_t                  cmd;
	blr_stat_t                 stat;
	logic signed [COORD_W-1:0] pixel_x;
	logic signed [COORD_W-1:0] pixel_y;
	logic        [COLOR_W-1:0] pixel_color;

	blr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	blr_dp u_dp (
		.clk         (clk),
		.start_x     (s_tdata[5:0]),
		.start_y     (s_tdata[11:6]),
		.end_x       (s_tdata[17:12]),
		.end_y       (s_tdata[23:18]),
		.line_color  (s_tdata[47:24]),
		.cmd         (cmd),
		.stat        (stat),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color)
	);

	assign m_tdata = {4'b0000, pixel_color, pixel_y, pixel_x};
	assign m_tlast = stat.last;

endmodule

[hdl/blr_checker.sv]
// ----------------------------------------------------------------------------
// blr_checker
// port-level checks of the line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`include "bresenham_line_rasterizer_assert.svh"

module blr_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [blr_pkg::OUT_W-1:0] m_tdata,
	input  logic                      m_tlast
);
	import blr_pkg::*;

	logic in_fire;
	logic out_fire;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	`BLR_ASSERT_NOW(a_one_line, clk, arst_n, 1'b1, !(s_tready && m_tvalid), "line overlap")
	`BLR_ASSERT_NEXT(a_first_pixel, clk, arst_n, in_fire, m_tvalid, "no first pixel")
	`BLR_ASSERT_NEXT(a_back_idle, clk, arst_n, out_fire && m_tlast, s_tready, "not idle after line")
	`BLR_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled pixel changed")

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);
